>>> src/tnbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbi_pkg: shared types and constants for the two-name bucket index block
// Holds the fixed field widths, the hash seed, the job word that passes
// from the front end to the back end, and the back-end state encoding.
// ----------------------------------------------------------------------------
package tnbi_pkg;

  localparam int HASH_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int HALF_SIZE_W = 9;
  localparam int BUCKET_W    = 16;
  localparam int HASH_SHIFT  = 5;

  localparam logic [HASH_W-1:0]      HASH_SEED      = 64'd5381;
  localparam logic [HALF_SIZE_W-1:0] HALF_SIZE_RESET = 9'd256;

  // Bits retired per cycle by the remainder unit, and its iterations per hash.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = HASH_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // One finished name handed from the front end to the back end.
  typedef struct packed {
    logic [HASH_W-1:0]      hash;
    logic                   last;
    logic [HALF_SIZE_W-1:0] half;
  } name_job_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic busy;
    logic first_wr;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_EMIT
  } back_state_t;

endpackage

>>> src/two_name_bucket_index_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_name_bucket_index_top: bucket index for a first and last name pair
// Hashes the bytes of a first and a last name and emits the bucket index.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_ready, one name byte per word with
//   flags for byte presence, which name is streaming and the name end.
//   A word with end_of_name set on the last name produces one output word
//   on out_valid/out_ready carrying bucket_index; other words produce none.
//   cfg_we/cfg_wdata write half_size; write it only while the block is
//   idle. Zero acts as one, values above MAX_HALF_SIZE saturate.
// Timing:
//   A byte word is taken every cycle while the queue has room. A remainder
//   unit retires four hash bits per cycle; a first-name end holds the back
//   end for the job fetch and the divide steps, and a last-name end also
//   for a multiply and an emit state. With the back end idle, a bucket
//   word is registered after the fetch, divide, multiply and emit states.
//   A two-entry queue lets later bytes flow while the remainder unit works.
// Reset and stall:
//   Reset reloads the hash seed, sets half_size to 256, clears the stored
//   first residue and empties the queue. While the receiver stalls the
//   output holds; the back end waits and the front end keeps taking words
//   until the queue is full.
// ----------------------------------------------------------------------------
module two_name_bucket_index_top #(
  parameter int MAX_HALF_SIZE = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tnbi_pkg::BYTE_W-1:0]      name_byte,
  input  logic                            byte_present,
  input  logic                            is_last_name,
  input  logic                            end_of_name,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tnbi_pkg::BUCKET_W-1:0]    bucket_index,
  input  logic                            cfg_we,
  input  logic [tnbi_pkg::HALF_SIZE_W-1:0] cfg_wdata
);
  import tnbi_pkg::*;

  // The nine-bit register never exceeds 511, so that bounds the half size.
  localparam int EFF_MAX = (MAX_HALF_SIZE < 511) ? MAX_HALF_SIZE : 511;
  localparam int RES_W   = $clog2(EFF_MAX);

  logic [HALF_SIZE_W-1:0] half_size;
  logic                   q_push;
  logic                   q_push_ready;
  logic                   q_pop;
  logic                   q_pop_valid;
  name_job_t              q_push_job;
  name_job_t              q_pop_job;
  back_status_t           back_st;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_size <= HALF_SIZE_RESET;
    end else if (cfg_we) begin
      half_size <= cfg_wdata;
    end
  end

  tnbi_front #(
    .HALF_CAP (EFF_MAX)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .name_byte    (name_byte),
    .byte_present (byte_present),
    .is_last_name (is_last_name),
    .end_of_name  (end_of_name),
    .half_size    (half_size),
    .push         (q_push),
    .push_job     (q_push_job),
    .push_ready   (q_push_ready)
  );

  tnbi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_job    (q_pop_job),
    .pop_valid  (q_pop_valid)
  );

  tnbi_back #(
    .RES_W (RES_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_job      (q_pop_job),
    .pop_valid    (q_pop_valid),
    .pop          (q_pop),
    .status       (back_st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bucket_index (bucket_index)
  );

`ifndef SYNTHESIS
  // A job is taken only from a non-empty queue and only by an idle back end.
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_pop_valid && !back_st.busy))
    else $error("job taken while back end busy or queue empty");

  // Taking a job always starts the remainder unit.
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> back_st.busy)
    else $error("back end did not start after taking a job");

  // A new output word only follows back-end work.
  a_out_from_back: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(back_st.busy))
    else $error("output appeared without back-end work");

  // Storing a first residue never coincides with a new output word.
  a_first_no_out: assert property (@(posedge clk) disable iff (rst)
    back_st.first_wr |=> !$rose(out_valid))
    else $error("first-name end produced an output word");
`endif

endmodule

>>> src/tnbi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbi_front: byte intake and running hash
// Takes one word per cycle while the queue has room, folds present bytes
// into the hash, and at each name end pushes the hash and clamped half size.
// ----------------------------------------------------------------------------
module tnbi_front #(
  parameter int HALF_CAP = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tnbi_pkg::BYTE_W-1:0]      name_byte,
  input  logic                            byte_present,
  input  logic                            is_last_name,
  input  logic                            end_of_name,
  input  logic [tnbi_pkg::HALF_SIZE_W-1:0] half_size,
  output logic                            push,
  output tnbi_pkg::name_job_t             push_job,
  input  logic                            push_ready
);
  import tnbi_pkg::*;

  localparam logic [HALF_SIZE_W-1:0] CAP = HALF_SIZE_W'(HALF_CAP);

  logic [HASH_W-1:0]      hash;
  logic [HASH_W-1:0]      hash_next;
  logic [HASH_W-1:0]      hash_upd;
  logic [HALF_SIZE_W-1:0] half_eff;
  logic                   accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Hash step: hash * 33 + byte, wrapping at 64 bits.
  assign hash_upd = byte_present
                  ? (hash << HASH_SHIFT) + hash + HASH_W'(name_byte)
                  : hash;

  // Zero counts as one; values above the cap saturate.
  always_comb begin
    if (half_size == '0) begin
      half_eff = HALF_SIZE_W'(1);
    end else if (half_size > CAP) begin
      half_eff = CAP;
    end else begin
      half_eff = half_size;
    end
  end

  assign push          = accept && end_of_name;
  assign push_job.hash = hash_upd;
  assign push_job.last = is_last_name;
  assign push_job.half = half_eff;

  // The hash reloads with the seed at every name end.
  always_comb begin
    hash_next = hash;
    if (accept) begin
      hash_next = end_of_name ? HASH_SEED : hash_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_SEED;
    end else begin
      hash <= hash_next;
    end
  end

endmodule

>>> src/tnbi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbi_queue: two-entry job queue
// Decouples the byte intake from the remainder unit so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module tnbi_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tnbi_pkg::name_job_t push_job,
  output logic                push_ready,
  input  logic                pop,
  output tnbi_pkg::name_job_t pop_job,
  output logic                pop_valid
);
  import tnbi_pkg::*;

  localparam int DEPTH = 2;

  name_job_t   slots [DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

>>> src/tnbi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbi_back: remainder unit and bucket output
// Reduces each hash modulo its half size four bits per cycle, keeps the
// first-name residue, and forms the bucket index for each last name.
// ----------------------------------------------------------------------------
module tnbi_back #(
  parameter int RES_W = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tnbi_pkg::name_job_t                pop_job,
  input  logic                               pop_valid,
  output logic                               pop,
  output tnbi_pkg::back_status_t             status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tnbi_pkg::BUCKET_W-1:0]      bucket_index
);
  import tnbi_pkg::*;

  localparam int MUL_W = HALF_SIZE_W + RES_W;

  back_state_t            state;
  back_state_t            state_next;
  logic [HASH_W-1:0]      dividend;
  logic [HASH_W-1:0]      dividend_next;
  logic [HALF_SIZE_W-1:0] rem;
  logic [HALF_SIZE_W-1:0] rem_next;
  logic [HALF_SIZE_W-1:0] half;
  logic                   last;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [RES_W-1:0]       first_residue;
  logic [RES_W-1:0]       last_residue;
  logic [MUL_W-1:0]       mul_full;
  logic [BUCKET_W-1:0]    prod;
  logic                   out_free;
  logic                   div_done;

  assign out_free = !out_valid || out_ready;
  assign div_done = (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));

  // Four restoring-division steps per cycle on a nine-bit remainder.
  always_comb begin
    logic [HALF_SIZE_W:0]   trial;
    logic [HALF_SIZE_W-1:0] r;
    logic [HASH_W-1:0]      d;
    r = rem;
    d = dividend;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r, d[HASH_W-1]};
      d     = d << 1;
      if (trial >= {1'b0, half}) begin
        r = HALF_SIZE_W'(trial - {1'b0, half});
      end else begin
        r = trial[HALF_SIZE_W-1:0];
      end
    end
    rem_next      = r;
    dividend_next = d;
  end

  assign mul_full = MUL_W'(half) * MUL_W'(last_residue);

  // Sequencer: idle, divide, multiply, emit.
  always_comb begin
    state_next      = state;
    pop             = 1'b0;
    status.busy     = (state != BK_IDLE);
    status.first_wr = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          pop        = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          if (last) begin
            state_next = BK_MUL;
          end else begin
            status.first_wr = 1'b1;
            state_next      = BK_IDLE;
          end
        end
      end
      BK_MUL: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      out_valid     <= 1'b0;
      first_residue <= '0;
    end else begin
      state <= state_next;
      if (status.first_wr) begin
        first_residue <= RES_W'(rem_next);
      end
      if (state == BK_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      dividend <= pop_job.hash;
      half     <= pop_job.half;
      last     <= pop_job.last;
      rem      <= '0;
      div_cnt  <= '0;
    end else if (state == BK_DIV) begin
      dividend <= dividend_next;
      rem      <= rem_next;
      div_cnt  <= div_cnt + DIV_CNT_W'(1);
      if (div_done) begin
        last_residue <= RES_W'(rem_next);
      end
    end
    if (state == BK_MUL) begin
      prod <= BUCKET_W'(mul_full);
    end
    if (state == BK_EMIT && out_free) begin
      bucket_index <= BUCKET_W'(first_residue) + prod;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the two-name bucket index block
// Streams first and last names into the block and checks every bucket word
// against a local djb2 predictor or a known value. A short directed table
// covers the corner cases, then random name sequences run under a series of
// half-size values, with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb;

  import tnbi_pkg::*;

  localparam int MAX_HALF     = 256;
  localparam int PHASE_WORDS  = 116;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int PLAN_LEN     = 11;

  // One row of the directed table; a known bucket overrides the predictor.
  typedef struct packed {
    logic [BYTE_W-1:0]   b;
    logic                present;
    logic                last;
    logic                eon;
    logic                known;
    logic [BUCKET_W-1:0] bucket;
  } name_row_t;

  localparam int DIR_ROWS = 19;

  // Reset state: hash 5381 gives residue 5 modulo 256.
  name_row_t dir_rows [DIR_ROWS] = '{
    '{8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},     // absent byte, no end: ignored
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1280},  // last name before any first name
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0},     // empty first name
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1285},  // empty last name
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1285},  // repeated last name
    '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0},     // present zero byte
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0},     // flag flips inside a name
    '{8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0},
    '{8'h7F, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0},
    '{8'h34, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0},     // absent byte inside a name
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0},
    '{8'h41, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0},     // repeated last name
    '{8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0},     // absent byte ends a name
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0}
  };

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [BYTE_W-1:0]      name_byte;
  logic                   byte_present;
  logic                   is_last_name;
  logic                   end_of_name;
  logic                   out_valid;
  logic                   out_ready;
  logic [BUCKET_W-1:0]    bucket_index;
  logic                   cfg_we;
  logic [HALF_SIZE_W-1:0] cfg_wdata;

  // Predictor state and the buckets still owed by the block.
  logic [HASH_W-1:0]      hash_acc;
  logic [BYTE_W-1:0]      first_res;
  logic [HALF_SIZE_W-1:0] half_cfg;
  logic [BUCKET_W-1:0]    pending_buckets [$];

  int  fail_count;
  int  words_sent;
  int  buckets_checked;
  int  settings_used;
  bit  quiet;

  two_name_bucket_index_top #(
    .MAX_HALF_SIZE(MAX_HALF)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .name_byte   (name_byte),
    .byte_present(byte_present),
    .is_last_name(is_last_name),
    .end_of_name (end_of_name),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bucket_index(bucket_index),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hash one word; on a name end reduce it and report whether a bucket results.
  function automatic bit predict_bucket(input logic [BYTE_W-1:0] b, input logic present,
                                        input logic last, input logic eon,
                                        output logic [BUCKET_W-1:0] bucket);
    logic [HASH_W-1:0] eff;
    logic [HASH_W-1:0] res;
    bucket = '0;
    if (present) begin
      hash_acc = (hash_acc << HASH_SHIFT) + hash_acc + HASH_W'(b);
    end
    if (!eon) begin
      return 1'b0;
    end
    if (half_cfg == '0) begin
      eff = HASH_W'(1);
    end else if (half_cfg > MAX_HALF) begin
      eff = HASH_W'(MAX_HALF);
    end else begin
      eff = HASH_W'(half_cfg);
    end
    res = hash_acc % eff;
    hash_acc = HASH_SEED;
    if (!last) begin
      first_res = BYTE_W'(res);
      return 1'b0;
    end
    bucket = BUCKET_W'(HASH_W'(first_res) + eff * res);
    return 1'b1;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hFF;
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Offer one word, wait for it to be taken, then record what it should yield.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic present,
                           input logic last, input logic eon,
                           input logic known, input logic [BUCKET_W-1:0] known_val);
    int gap;
    logic [BUCKET_W-1:0] model_val;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    name_byte    <= b;
    byte_present <= present;
    is_last_name <= last;
    end_of_name  <= eon;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (present || eon) begin
      words_sent++;
    end
    if (predict_bucket(b, present, last, eon, model_val)) begin
      pending_buckets.push_back(known ? known_val : model_val);
    end
  endtask

  // One name: random bytes, ended either on its last byte or by an absent-byte marker.
  task automatic send_name(input logic last, input bit scramble);
    int len;
    int r;
    int k;
    bit end_on_byte;
    logic flag;
    r = $urandom_range(0, 99);
    len = (r < 15) ? 0 : (r < 90) ? $urandom_range(1, 8) : $urandom_range(9, 24);
    end_on_byte = $urandom_range(0, 1);
    for (k = 0; k < len; k++) begin
      flag = scramble ? logic'($urandom_range(0, 1)) : last;
      if ($urandom_range(0, 19) == 0) begin
        send_word(pick_byte(), 1'b0, flag, 1'b0, 1'b0, '0);
      end
      if (k == len - 1 && end_on_byte) begin
        send_word(pick_byte(), 1'b1, last, 1'b1, 1'b0, '0);
      end else begin
        send_word(pick_byte(), 1'b1, flag, 1'b0, 1'b0, '0);
      end
    end
    if (len == 0 || !end_on_byte) begin
      send_word(pick_byte(), 1'b0, last, 1'b1, 1'b0, '0);
    end
  endtask

  // Mostly complete name pairs, plus lone names, noise and scrambled flags.
  task automatic random_traffic(input int target);
    int kind;
    while (words_sent < target) begin
      if ($urandom_range(0, 29) == 0) begin
        quiet = !quiet;
      end
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        send_name(1'b0, 1'b0);
        send_name(1'b1, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          send_name(1'b1, 1'b0);
        end
      end else if (kind < 78) begin
        send_name(1'b1, 1'b0);
      end else if (kind < 86) begin
        send_name(1'b0, 1'b0);
      end else if (kind < 92) begin
        send_word(pick_byte(), 1'b0, logic'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
      end else begin
        send_name(logic'($urandom_range(0, 1)), 1'b1);
      end
    end
  endtask

  // Hold the sender until every bucket is back and the back end has settled.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_size(input logic [HALF_SIZE_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    half_cfg = value;
    settings_used++;
  endtask

  // Receiver: check each bucket word, then decide on the next stall.
  initial begin : receiver
    int stall_left;
    logic [BUCKET_W-1:0] want;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_buckets.size() == 0) begin
          $error("bucket_index: unexpected word, actual %0d", bucket_index);
          fail_count++;
        end else begin
          want = pending_buckets.pop_front();
          buckets_checked++;
          if (bucket_index !== want) begin
            $error("bucket_index mismatch: expected %0d, actual %0d", want, bucket_index);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 25) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases per half size.
  initial begin : stimulus
    int row;
    int ph;
    logic [HALF_SIZE_W-1:0] plan [PLAN_LEN];
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    name_byte    <= '0;
    byte_present <= 1'b0;
    is_last_name <= 1'b0;
    end_of_name  <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    hash_acc  = HASH_SEED;
    first_res = '0;
    half_cfg  = HALF_SIZE_RESET;
    fail_count = 0;
    words_sent = 0;
    buckets_checked = 0;
    settings_used = 1;
    quiet = 1'b0;
    plan = '{9'd1, 9'd0, 9'd511, 9'd257, 9'd255, 9'd2, 9'd256, 9'd3, 9'd128, 9'd0, 9'd0};
    plan[PLAN_LEN-2] = HALF_SIZE_W'($urandom_range(1, 511));
    plan[PLAN_LEN-1] = HALF_SIZE_W'($urandom_range(1, 255));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases under the reset half size.
    for (row = 0; row < DIR_ROWS; row++) begin
      send_word(dir_rows[row].b, dir_rows[row].present, dir_rows[row].last,
                dir_rows[row].eon, dir_rows[row].known, dir_rows[row].bucket);
    end

    // Random phases, each under a new half size written while idle.
    for (ph = 0; ph < PLAN_LEN; ph++) begin
      wait_for_idle();
      write_half_size(plan[ph]);
      random_traffic(words_sent + PHASE_WORDS);
    end
    wait_for_idle();

    $display("Sent %0d name words under %0d half-size settings.", words_sent, settings_used);
    $display("Checked %0d bucket words with %0d mismatches.", buckets_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
